// ===== rtl/battery_level_guard_defines.svh =====
// Assertion macros shared by the battery level guard RTL.
// No dependencies; included by modules that carry assertions.
`ifndef BATTERY_LEVEL_GUARD_DEFINES_SVH
`define BATTERY_LEVEL_GUARD_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BLG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("battery_level_guard: assertion failed");

// Next-cycle implication, checked outside reset
`define BLG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("battery_level_guard: assertion failed");

`endif

// ===== rtl/blg_pkg.sv =====
// Types, register map and reset constants for the battery level guard.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package blg_pkg;

    localparam int TIME_WIDTH_DEF = 32;

    localparam int PCT_W      = 7;
    localparam int STREAK_W   = 8;
    localparam int COOLDOWN_W = 22;
    localparam int DELAY_W    = 16;
    localparam int LEVEL_W    = 8;
    localparam int TIER_W     = 2;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_LOW_WARN_PCT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CRIT_PCT       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STREAK_TO_SHDN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LOW_COOLDOWN   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CRIT_COOLDOWN  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SHDN_DELAY     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TIER_TWO_PCT   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_TIER_ONE_PCT   = 3'd7;

    localparam logic [PCT_W-1:0]      RST_LOW_WARN_PCT   = 7'd15;
    localparam logic [PCT_W-1:0]      RST_CRIT_PCT       = 7'd5;
    localparam logic [STREAK_W-1:0]   RST_STREAK_TO_SHDN = 8'd2;
    localparam logic [COOLDOWN_W-1:0] RST_LOW_COOLDOWN   = 22'd900000;
    localparam logic [COOLDOWN_W-1:0] RST_CRIT_COOLDOWN  = 22'd300000;
    localparam logic [DELAY_W-1:0]    RST_SHDN_DELAY     = 16'd3000;
    localparam logic [PCT_W-1:0]      RST_TIER_TWO_PCT   = 7'd10;
    localparam logic [PCT_W-1:0]      RST_TIER_ONE_PCT   = 7'd20;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [TIER_W-1:0] TIER_FULL = 2'd0;
    localparam logic [TIER_W-1:0] TIER_ONE  = 2'd1;
    localparam logic [TIER_W-1:0] TIER_TWO  = 2'd2;

    localparam logic [STREAK_W-1:0] STREAK_MAX = 8'hFF;

    typedef struct packed {
        logic [PCT_W-1:0]      low_warn_pct;
        logic [PCT_W-1:0]      crit_pct;
        logic [STREAK_W-1:0]   streak_to_shdn;
        logic [COOLDOWN_W-1:0] low_cooldown;
        logic [COOLDOWN_W-1:0] crit_cooldown;
        logic [DELAY_W-1:0]    shdn_delay;
        logic [PCT_W-1:0]      tier_two_pct;
        logic [PCT_W-1:0]      tier_one_pct;
    } cfg_t;

    // last member lands in bit 0, so tier_set is the lowest bit when packed
    typedef struct packed {
        logic              shutdown_now;
        logic              shutdown_notice;
        logic              warn_critical;
        logic [PCT_W-1:0]  warn_level;
        logic              warn_low;
        logic [TIER_W-1:0] power_tier;
        logic              tier_set;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

// ===== rtl/blg_apb_regs.sv =====
// APB configuration registers of the battery level guard.
// Depends on blg_pkg for the register map and reset values.
`timescale 1ns / 1ps
`default_nettype none

module blg_apb_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [blg_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [blg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [blg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output blg_pkg::cfg_t                          cfg
);

    blg_pkg::cfg_t                    cfg_reg;
    logic [blg_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[blg_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_warn_pct   <= blg_pkg::RST_LOW_WARN_PCT;
            cfg_reg.crit_pct       <= blg_pkg::RST_CRIT_PCT;
            cfg_reg.streak_to_shdn <= blg_pkg::RST_STREAK_TO_SHDN;
            cfg_reg.low_cooldown   <= blg_pkg::RST_LOW_COOLDOWN;
            cfg_reg.crit_cooldown  <= blg_pkg::RST_CRIT_COOLDOWN;
            cfg_reg.shdn_delay     <= blg_pkg::RST_SHDN_DELAY;
            cfg_reg.tier_two_pct   <= blg_pkg::RST_TIER_TWO_PCT;
            cfg_reg.tier_one_pct   <= blg_pkg::RST_TIER_ONE_PCT;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                blg_pkg::REG_LOW_WARN_PCT:
                    cfg_reg.low_warn_pct <= pwdata[blg_pkg::PCT_W-1:0];
                blg_pkg::REG_CRIT_PCT:
                    cfg_reg.crit_pct <= pwdata[blg_pkg::PCT_W-1:0];
                blg_pkg::REG_STREAK_TO_SHDN:
                    cfg_reg.streak_to_shdn <= pwdata[blg_pkg::STREAK_W-1:0];
                blg_pkg::REG_LOW_COOLDOWN:
                    cfg_reg.low_cooldown <= pwdata[blg_pkg::COOLDOWN_W-1:0];
                blg_pkg::REG_CRIT_COOLDOWN:
                    cfg_reg.crit_cooldown <= pwdata[blg_pkg::COOLDOWN_W-1:0];
                blg_pkg::REG_SHDN_DELAY:
                    cfg_reg.shdn_delay <= pwdata[blg_pkg::DELAY_W-1:0];
                blg_pkg::REG_TIER_TWO_PCT:
                    cfg_reg.tier_two_pct <= pwdata[blg_pkg::PCT_W-1:0];
                blg_pkg::REG_TIER_ONE_PCT:
                    cfg_reg.tier_one_pct <= pwdata[blg_pkg::PCT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            blg_pkg::REG_LOW_WARN_PCT:
                prdata = blg_pkg::APB_DATA_W'(cfg_reg.low_warn_pct);
            blg_pkg::REG_CRIT_PCT:
                prdata = blg_pkg::APB_DATA_W'(cfg_reg.crit_pct);
            blg_pkg::REG_STREAK_TO_SHDN:
                prdata = blg_pkg::APB_DATA_W'(cfg_reg.streak_to_shdn);
            blg_pkg::REG_LOW_COOLDOWN:
                prdata = blg_pkg::APB_DATA_W'(cfg_reg.low_cooldown);
            blg_pkg::REG_CRIT_COOLDOWN:
                prdata = blg_pkg::APB_DATA_W'(cfg_reg.crit_cooldown);
            blg_pkg::REG_SHDN_DELAY:
                prdata = blg_pkg::APB_DATA_W'(cfg_reg.shdn_delay);
            blg_pkg::REG_TIER_TWO_PCT:
                prdata = blg_pkg::APB_DATA_W'(cfg_reg.tier_two_pct);
            blg_pkg::REG_TIER_ONE_PCT:
                prdata = blg_pkg::APB_DATA_W'(cfg_reg.tier_one_pct);
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/blg_core.sv =====
// Guard state (time, warn stamps, critical streak, shutdown countdown) and
// the single-pass decision logic. Depends on blg_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "battery_level_guard_defines.svh"

module blg_core #(
    parameter int TIME_WIDTH = blg_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            fire,
    input  wire logic                            opcode,
    input  wire logic signed [blg_pkg::LEVEL_W-1:0] level,
    input  wire logic                            charging,
    input  wire blg_pkg::cfg_t                   cfg,
    output blg_pkg::result_t                     result
);

    logic [TIME_WIDTH-1:0]           time_reg, time_next;
    logic [TIME_WIDTH-1:0]           low_stamp_reg, low_stamp_next;
    logic [TIME_WIDTH-1:0]           crit_stamp_reg, crit_stamp_next;
    logic [blg_pkg::STREAK_W-1:0]    streak_reg, streak_next;
    logic                            armed_reg, armed_next;
    logic [blg_pkg::DELAY_W-1:0]     remaining_reg, remaining_next;

    logic [blg_pkg::PCT_W-1:0]       lvl;
    logic [blg_pkg::STREAK_W-1:0]    streak_inc;
    logic [TIME_WIDTH-1:0]           low_elapsed;
    logic [TIME_WIDTH-1:0]           crit_elapsed;
    logic                            low_cooled;
    logic                            crit_cooled;

    assign lvl          = level[blg_pkg::PCT_W-1:0];
    assign streak_inc   = (streak_reg == blg_pkg::STREAK_MAX) ? streak_reg
                                                              : streak_reg + 1'b1;
    assign low_elapsed  = time_reg - low_stamp_reg;
    assign crit_elapsed = time_reg - crit_stamp_reg;
    assign low_cooled   = low_elapsed >= TIME_WIDTH'(cfg.low_cooldown);
    assign crit_cooled  = crit_elapsed >= TIME_WIDTH'(cfg.crit_cooldown);

    always_comb
    begin
        time_next       = time_reg;
        low_stamp_next  = low_stamp_reg;
        crit_stamp_next = crit_stamp_reg;
        streak_next     = streak_reg;
        armed_next      = armed_reg;
        remaining_next  = remaining_reg;
        result          = '0;

        if (opcode == blg_pkg::OP_TICK)
        begin
            time_next = time_reg + 1'b1;
            if (armed_reg)
            begin
                if (remaining_reg <= blg_pkg::DELAY_W'(1))
                begin
                    armed_next          = 1'b0;
                    remaining_next      = '0;
                    result.shutdown_now = 1'b1;
                end
                else
                begin
                    remaining_next = remaining_reg - 1'b1;
                end
            end
        end
        else if (!level[blg_pkg::LEVEL_W-1])
        begin
            result.tier_set = 1'b1;
            if (charging)
            begin
                result.power_tier = blg_pkg::TIER_FULL;
                streak_next       = '0;
                armed_next        = 1'b0;
                remaining_next    = '0;
            end
            else
            begin
                if (lvl <= cfg.tier_two_pct)
                    result.power_tier = blg_pkg::TIER_TWO;
                else if (lvl <= cfg.tier_one_pct)
                    result.power_tier = blg_pkg::TIER_ONE;
                else
                    result.power_tier = blg_pkg::TIER_FULL;

                if (lvl <= cfg.crit_pct)
                begin
                    streak_next = streak_inc;
                    if (crit_cooled)
                    begin
                        result.warn_critical = 1'b1;
                        crit_stamp_next      = time_reg;
                    end
                    // compare uses the streak including this sample
                    if ((streak_inc >= cfg.streak_to_shdn) && !armed_reg)
                    begin
                        armed_next             = 1'b1;
                        remaining_next         = cfg.shdn_delay;
                        result.shutdown_notice = 1'b1;
                    end
                end
                else
                begin
                    streak_next    = '0;
                    armed_next     = 1'b0;
                    remaining_next = '0;
                    if ((lvl <= cfg.low_warn_pct) && low_cooled)
                    begin
                        result.warn_low   = 1'b1;
                        result.warn_level = lvl;
                        low_stamp_next    = time_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg       <= '0;
            low_stamp_reg  <= '0;
            crit_stamp_reg <= '0;
            streak_reg     <= '0;
            armed_reg      <= 1'b0;
            remaining_reg  <= '0;
        end
        else if (fire)
        begin
            time_reg       <= time_next;
            low_stamp_reg  <= low_stamp_next;
            crit_stamp_reg <= crit_stamp_next;
            streak_reg     <= streak_next;
            armed_reg      <= armed_next;
            remaining_reg  <= remaining_next;
        end
    end

    // countdown value is only meaningful while armed
    `BLG_ASSERT_IMP(a_idle_count_zero, clk, rst_n, !armed_reg, remaining_reg == '0)
    `BLG_ASSERT_IMP(a_now_needs_armed, clk, rst_n, fire && result.shutdown_now, armed_reg)
    `BLG_ASSERT_NEXT(a_notice_arms, clk, rst_n, fire && result.shutdown_notice, armed_reg)
    `BLG_ASSERT_NEXT(a_crit_keeps_streak, clk, rst_n,
        fire && result.warn_critical, streak_reg != '0)

endmodule

`default_nettype wire

// ===== rtl/battery_level_guard.sv =====
// Battery level guard: one item is accepted per clock cycle when the output
// side keeps up. Each accepted item yields exactly one result. The result
// passes the input register, one pass of compare and count logic and the
// result register before it is offered on the result stream. While a result
// waits, the input register can still take one more item. Configuration
// registers are written over APB at byte address 4*index; the user must write
// them only while no item is in flight, and the block does not enforce this.
// Depends on blg_pkg, blg_apb_regs and blg_core.
`timescale 1ns / 1ps
`default_nettype none

module battery_level_guard #(
    parameter int TIME_WIDTH = blg_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [blg_pkg::S_TDATA_W-1:0]     s_tdata,  // level[7:0], charging[8]
    input  wire logic                              s_tuser,  // opcode[0]
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // tier_set[0], power_tier[2:1], warn_low[3], warn_level[10:4],
    // warn_critical[11], shutdown_notice[12], shutdown_now[13]
    output logic      [blg_pkg::M_TDATA_W-1:0]     m_tdata,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [blg_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [blg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [blg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    blg_pkg::cfg_t                          cfg;
    blg_pkg::result_t                       result;

    logic                                   in_valid_reg;
    logic                                   in_opcode_reg;
    logic signed [blg_pkg::LEVEL_W-1:0]     in_level_reg;
    logic                                   in_charging_reg;
    logic                                   out_valid_reg;
    blg_pkg::result_t                       out_data_reg;
    logic                                   fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = blg_pkg::M_TDATA_W'(out_data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_opcode_reg   <= s_tuser;
            in_level_reg    <= s_tdata[blg_pkg::LEVEL_W-1:0];
            in_charging_reg <= s_tdata[blg_pkg::LEVEL_W];
        end
        if (fire)
            out_data_reg <= result;
    end

    blg_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    blg_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .opcode   (in_opcode_reg),
        .level    (in_level_reg),
        .charging (in_charging_reg),
        .cfg      (cfg),
        .result   (result)
    );

endmodule

`default_nettype wire
